@@ src/mrrs_pkg.sv @@
package mrrs_pkg;

  localparam int unsigned SpeedW   = 10;
  localparam int unsigned TempW    = 8;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [SpeedW-1:0] SpeedMax         = SpeedW'(1000);
  localparam logic [SpeedW-1:0] TargetSpeedReset = SpeedW'(800);
  localparam logic [SpeedW-1:0] AccelStepReset   = SpeedW'(100);
  localparam logic [SpeedW-1:0] DecelStepReset   = SpeedW'(100);
  localparam logic [TempW-1:0]  TempLimitReset   = TempW'(80);
  localparam logic [TicksW-1:0] RunTicksReset    = TicksW'(60);

  typedef enum logic [1:0] {
    PhaseIdle     = 2'd0,
    PhaseRampUp   = 2'd1,
    PhaseRun      = 2'd2,
    PhaseRampDown = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ReasonNone      = 3'd0,
    ReasonCompleted = 3'd1,
    ReasonDoorRef   = 3'd2,
    ReasonEstopRef  = 3'd3,
    ReasonSafeTrip  = 3'd4,
    ReasonOverTemp  = 3'd5
  } reason_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTargetSpeed = 3'd0,
    CfgAccelStep   = 3'd1,
    CfgDecelStep   = 3'd2,
    CfgTempLimit   = 3'd3,
    CfgRunTicks    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic             start_req;
    logic             door_closed;
    logic             estop;
    logic [TempW-1:0] temperature;
  } in_t;

  typedef struct packed {
    logic [SpeedW-1:0] speed;
    logic              pwm_on;
    logic              running;
    logic [1:0]        phase;
    logic [2:0]        stop_reason;
  } out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [SpeedW-1:0] top_speed;
    logic [SpeedW-1:0] accel_step;
    logic [SpeedW-1:0] decel_step;
    logic [TempW-1:0]  temp_limit;
    logic [TicksW-1:0] run_ticks;
  } cfg_t;

  typedef struct packed {
    phase_e            phase;
    logic [SpeedW-1:0] speed;
    logic [TicksW-1:0] elapsed;
    logic              running;
    reason_e           reason;
  } state_t;

endpackage

@@ src/mrrs_stream_if.sv @@
interface mrrs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ src/motor_ramp_run_sequencer_unit.sv @@
// Motor soft-start ramp and run sequencer.
// in_i carries one tick request per item: start request, door switch,
// emergency stop and a temperature sample. out_o returns exactly one
// result per tick: speed, pwm on, running, phase and last stop reason.
// cfg_i writes the five setup registers (index 0..4: target speed,
// accel step, decel step, temperature limit, run ticks); other indexes
// are dropped. cfg_i is always ready.
// Latency: the result of a tick is valid the cycle after it is accepted.
// Throughput: one tick per cycle; the sequencer state and the result
// register both update in the accept cycle from one pass of step logic.
// in_i.ready is high while the result register is empty or being taken,
// so a stalled receiver holds its result and blocks new ticks, with
// nothing lost.
// Reset: idle, speed zero, reason none, no result pending; registers
// return to target 800, steps 100, limit 80, run ticks 60.
module motor_ramp_run_sequencer_unit
  import mrrs_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  mrrs_stream_if.sink   cfg_i,
  mrrs_stream_if.sink   in_i,
  mrrs_stream_if.source out_o
);

  cfg_t   cfg_q;
  state_t state_q;
  state_t state_d;
  out_t   out_q;
  logic   out_valid_q;
  logic   in_fire;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.top_speed  <= TargetSpeedReset;
      cfg_q.accel_step <= AccelStepReset;
      cfg_q.decel_step <= DecelStepReset;
      cfg_q.temp_limit <= TempLimitReset;
      cfg_q.run_ticks  <= RunTicksReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        CfgTargetSpeed: cfg_q.top_speed  <= cfg_i.payload.data[SpeedW-1:0];
        CfgAccelStep:   cfg_q.accel_step <= cfg_i.payload.data[SpeedW-1:0];
        CfgDecelStep:   cfg_q.decel_step <= cfg_i.payload.data[SpeedW-1:0];
        CfgTempLimit:   cfg_q.temp_limit <= cfg_i.payload.data[TempW-1:0];
        CfgRunTicks:    cfg_q.run_ticks  <= cfg_i.payload.data[TicksW-1:0];
        default: ;
      endcase
    end
  end

  mrrs_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .item_i  (in_i.payload),
    .state_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase   <= PhaseIdle;
      state_q.speed   <= '0;
      state_q.elapsed <= '0;
      state_q.running <= 1'b0;
      state_q.reason  <= ReasonNone;
      out_valid_q     <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q.speed       <= state_d.speed;
      out_q.pwm_on      <= (state_d.speed != '0);
      out_q.running     <= state_d.running;
      out_q.phase       <= state_d.phase;
      out_q.stop_reason <= state_d.reason;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

@@ src/mrrs_step.sv @@
module mrrs_step
  import mrrs_pkg::*;
(
  input  state_t state_i,
  input  cfg_t   cfg_i,
  input  in_t    item_i,
  output state_t state_o
);

  logic [SpeedW-1:0] tgt;
  logic [SpeedW-1:0] acc;
  logic [SpeedW-1:0] dec;
  logic [SpeedW:0]   up_sum;
  logic [SpeedW-1:0] up_speed;
  logic [SpeedW-1:0] dn_speed;
  logic              do_up;
  logic              do_down;

  always_comb begin
    tgt = (cfg_i.top_speed > SpeedMax) ? SpeedMax : cfg_i.top_speed;
    acc = (cfg_i.accel_step == '0) ? SpeedW'(1) : cfg_i.accel_step;
    dec = (cfg_i.decel_step == '0) ? SpeedW'(1) : cfg_i.decel_step;
    up_sum = {1'b0, state_i.speed} + {1'b0, acc};
    if (state_i.speed < tgt) begin
      up_speed = (up_sum > {1'b0, tgt}) ? tgt : up_sum[SpeedW-1:0];
    end else if (state_i.speed > tgt) begin
      up_speed = ((state_i.speed - tgt) > acc) ? state_i.speed - acc : tgt;
    end else begin
      up_speed = tgt;
    end
    dn_speed = (state_i.speed > dec) ? state_i.speed - dec : '0;
  end

  always_comb begin
    state_o = state_i;
    do_up   = 1'b0;
    do_down = 1'b0;
    unique case (state_i.phase)
      PhaseIdle: begin
        if (item_i.start_req) begin
          if (!item_i.door_closed) begin
            state_o.reason = ReasonDoorRef;
          end else if (item_i.estop) begin
            state_o.reason = ReasonEstopRef;
          end else begin
            state_o.reason = ReasonNone;
            do_up = 1'b1;
          end
        end
      end
      PhaseRampUp: do_up = 1'b1;
      PhaseRun: begin
        if (state_i.elapsed >= cfg_i.run_ticks) begin
          state_o.reason = ReasonCompleted;
          do_down = 1'b1;
        end else if (!item_i.door_closed || item_i.estop) begin
          state_o.reason = ReasonSafeTrip;
          do_down = 1'b1;
        end else if (item_i.temperature > cfg_i.temp_limit) begin
          state_o.reason = ReasonOverTemp;
          do_down = 1'b1;
        end else begin
          state_o.elapsed = state_i.elapsed + TicksW'(1);
        end
      end
      PhaseRampDown: do_down = 1'b1;
      default: ;
    endcase

    if (do_up) begin
      state_o.speed = up_speed;
      if (up_speed == tgt) begin
        state_o.running = 1'b1;
        state_o.phase   = PhaseRun;
        state_o.elapsed = '0;
      end else begin
        state_o.phase = PhaseRampUp;
      end
    end else if (do_down) begin
      state_o.speed = dn_speed;
      if (dn_speed == '0) begin
        state_o.running = 1'b0;
        state_o.phase   = PhaseIdle;
      end else begin
        state_o.phase = PhaseRampDown;
      end
    end
  end

endmodule

@@ src/mrrs_checker.sv @@
module mrrs_checker
  import mrrs_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // every accepted tick yields a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> out_valid)
    else $error("result missing after accepted tick");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.pwm_on == (out_data.speed != '0))
    else $error("pwm_on does not track speed");

  // idle means stopped; ramping up means not yet running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_data.phase == PhaseIdle || out_data.phase == PhaseRampUp)
      |-> !out_data.running && (out_data.phase == PhaseRampUp || out_data.speed == '0))
    else $error("idle or ramp up with inconsistent speed or running");

endmodule

bind motor_ramp_run_sequencer_unit mrrs_checker u_mrrs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.payload)
);
